[hdl/stt_pkg.sv]
package stt_pkg;

  localparam int LINE_BITS   = 16;
  localparam int POS_BITS    = 16;
  localparam int VALUE_BITS  = 31;
  localparam int KIND_BITS   = 6;
  localparam int PREFIX_BITS = 56;
  localparam int PREFIX_LEN  = 7;
  localparam int NUM_KW      = 12;

  localparam logic [KIND_BITS-1:0] KIND_LPAREN = 6'd0;
  localparam logic [KIND_BITS-1:0] KIND_RPAREN = 6'd1;
  localparam logic [KIND_BITS-1:0] KIND_LBRACE = 6'd2;
  localparam logic [KIND_BITS-1:0] KIND_RBRACE = 6'd3;
  localparam logic [KIND_BITS-1:0] KIND_COMMA  = 6'd4;
  localparam logic [KIND_BITS-1:0] KIND_SEMI   = 6'd5;
  localparam logic [KIND_BITS-1:0] KIND_PLUS   = 6'd6;
  localparam logic [KIND_BITS-1:0] KIND_MINUS  = 6'd7;
  localparam logic [KIND_BITS-1:0] KIND_STAR   = 6'd8;
  localparam logic [KIND_BITS-1:0] KIND_SLASH  = 6'd9;
  localparam logic [KIND_BITS-1:0] KIND_ASSIGN = 6'd10;
  localparam logic [KIND_BITS-1:0] KIND_EQ     = 6'd11;
  localparam logic [KIND_BITS-1:0] KIND_STRING = 6'd18;
  localparam logic [KIND_BITS-1:0] KIND_INT    = 6'd19;
  localparam logic [KIND_BITS-1:0] KIND_DEC    = 6'd20;
  localparam logic [KIND_BITS-1:0] KIND_IDENT  = 6'd21;
  localparam logic [KIND_BITS-1:0] KIND_KW0    = 6'd22;
  localparam logic [KIND_BITS-1:0] KIND_END    = 6'd34;
  localparam logic [KIND_BITS-1:0] KIND_ERROR  = 6'd0;

  // held operator codes
  localparam logic [1:0] OP_EQ   = 2'd0;
  localparam logic [1:0] OP_BANG = 2'd1;
  localparam logic [1:0] OP_GT   = 2'd2;
  localparam logic [1:0] OP_LT   = 2'd3;

  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;

  // keyword text, right aligned, in kind order
  localparam logic [PREFIX_BITS-1:0] KW_WORD [NUM_KW] = '{
    56'h74727565,         // true
    56'h66616c7365,       // false
    56'h6966,             // if
    56'h656c7365,         // else
    56'h666f72,           // for
    56'h7768696c65,       // while
    56'h6563686f,         // echo
    56'h65786563,         // exec
    56'h696e74,           // int
    56'h646f75626c65,     // double
    56'h737472696e67,     // string
    56'h626f6f6c65616e    // boolean
  };
  localparam logic [2:0] KW_LEN [NUM_KW] = '{
    3'd4, 3'd5, 3'd2, 3'd4, 3'd3, 3'd5, 3'd4, 3'd4, 3'd3, 3'd6, 3'd6, 3'd7
  };

  typedef struct packed {
    logic [KIND_BITS-1:0]  kind;
    logic [LINE_BITS-1:0]  line;
    logic [POS_BITS-1:0]   start;
    logic [POS_BITS-1:0]   length;
    logic [VALUE_BITS-1:0] value;
    logic                  sat;
    logic                  err;
    logic                  lst;
  } tok_t;

  typedef struct packed {
    tok_t       r0;
    tok_t       r1;
    logic [1:0] n;
  } push_t;

  function automatic tok_t make_tok(input logic [KIND_BITS-1:0] kind,
                                    input logic [LINE_BITS-1:0] line,
                                    input logic [POS_BITS-1:0] start,
                                    input logic [POS_BITS-1:0] length,
                                    input logic [VALUE_BITS-1:0] value,
                                    input logic sat, input logic err,
                                    input logic lst);
    tok_t t;
    t.kind   = kind;
    t.line   = line;
    t.start  = start;
    t.length = length;
    t.value  = value;
    t.sat    = sat;
    t.err    = err;
    t.lst    = lst;
    return t;
  endfunction

  function automatic logic [KIND_BITS-1:0] word_kind(
      input logic [PREFIX_BITS-1:0] prefix, input logic [POS_BITS-1:0] len);
    logic [KIND_BITS-1:0] k;
    k = KIND_IDENT;
    for (int i = 0; i < NUM_KW; i++) begin
      if (len == POS_BITS'(KW_LEN[i]) && prefix == KW_WORD[i]) begin
        k = KIND_KW0 + KIND_BITS'(i);
      end
    end
    return k;
  endfunction

  // acc*10 + digit, pinned at full scale with a sticky flag
  function automatic logic [VALUE_BITS:0] add_digit(input logic [VALUE_BITS-1:0] acc,
                                                    input logic ovf,
                                                    input logic [7:0] ch);
    logic [VALUE_BITS+3:0] p;
    p = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + (VALUE_BITS+4)'(ch[3:0]);
    if (p > (VALUE_BITS+4)'({VALUE_BITS{1'b1}})) begin
      return {1'b1, {VALUE_BITS{1'b1}}};
    end
    return {ovf, p[VALUE_BITS-1:0]};
  endfunction

endpackage

[hdl/stt_scan.sv]
module stt_scan import stt_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] ch,
  input  logic       eos,
  output push_t      push
);

  localparam logic [3:0] M_IDLE  = 4'd0;
  localparam logic [3:0] M_SLASH = 4'd1;
  localparam logic [3:0] M_LCOMM = 4'd2;
  localparam logic [3:0] M_BCOMM = 4'd3;
  localparam logic [3:0] M_BSTAR = 4'd4;
  localparam logic [3:0] M_OP    = 4'd5;
  localparam logic [3:0] M_STR   = 4'd6;
  localparam logic [3:0] M_INT   = 4'd7;
  localparam logic [3:0] M_FRAC  = 4'd8;
  localparam logic [3:0] M_IDENT = 4'd9;
  localparam logic [3:0] M_HALT  = 4'd10;

  logic [3:0]             mode, mode_next;
  logic [1:0]             op, op_next;
  logic [LINE_BITS-1:0]   line, line_next, line_inc;
  logic [POS_BITS-1:0]    pos, pos_next;
  logic [POS_BITS-1:0]    st, st_next;
  logic [POS_BITS-1:0]    len, len_next, len_grow;
  logic [VALUE_BITS-1:0]  acc, acc_next;
  logic                   ovf, ovf_next;
  logic [PREFIX_BITS-1:0] pre, pre_next;

  logic       is_dig, is_alp, taken, fl_hit, fr_hit;
  tok_t       fl_tok, fr_tok, end_tok;
  logic [VALUE_BITS:0] dsum;

  assign is_dig   = ch >= 8'h30 && ch <= 8'h39;
  assign is_alp   = (ch >= 8'h61 && ch <= 8'h7A) || (ch >= 8'h41 && ch <= 8'h5A);
  assign line_inc = (line == '1) ? line : line + 1'b1;
  assign len_grow = (len == '1) ? len : len + 1'b1;
  assign dsum     = add_digit(acc, ovf, ch);

  // held token, as it stands before this character
  always_comb begin
    fl_hit = 1'b1;
    fl_tok = make_tok(KIND_SLASH, line, st, len, '0, 1'b0, 1'b0, 1'b0);
    unique case (mode)
      M_SLASH: fl_tok.kind = KIND_SLASH;
      M_OP:    fl_tok.kind = KIND_ASSIGN + {3'b000, op, 1'b0};
      M_INT: begin
        fl_tok.kind  = KIND_INT;
        fl_tok.value = acc;
        fl_tok.sat   = ovf;
      end
      M_FRAC: begin
        fl_tok.kind  = KIND_DEC;
        fl_tok.value = acc;
        fl_tok.sat   = ovf;
      end
      M_IDENT: fl_tok.kind = word_kind(pre, len);
      default: fl_hit = 1'b0;
    endcase
  end

  assign end_tok = make_tok(KIND_END, line, pos, '0, '0, 1'b0, 1'b0, 1'b1);

  always_comb begin
    mode_next = mode;
    op_next   = op;
    line_next = line;
    pos_next  = (pos == '1) ? pos : pos + 1'b1;
    st_next   = st;
    len_next  = len;
    acc_next  = acc;
    ovf_next  = ovf;
    pre_next  = pre;
    push      = '0;
    taken     = 1'b1;
    fr_hit    = 1'b0;
    fr_tok    = make_tok(KIND_ERROR, line, pos, POS_BITS'(1), '0, 1'b0, 1'b0, 1'b0);
    if (mode == M_HALT) begin
      pos_next = pos;
    end else if (eos) begin
      pos_next  = pos;
      mode_next = M_HALT;
      if (mode == M_STR) begin
        push.r0 = make_tok(KIND_ERROR, line, st, len, '0, 1'b0, 1'b1, 1'b1);
        push.n  = 2'd1;
      end else if (fl_hit) begin
        push.r0 = fl_tok;
        push.r1 = end_tok;
        push.n  = 2'd2;
      end else begin
        push.r0 = end_tok;
        push.n  = 2'd1;
      end
    end else begin
      unique case (mode)
        M_LCOMM: begin
          if (ch == CH_NL) begin
            line_next = line_inc;
            mode_next = M_IDLE;
          end
        end
        M_BCOMM: begin
          if (ch == CH_STAR) mode_next = M_BSTAR;
          else if (ch == CH_NL) line_next = line_inc;
        end
        M_BSTAR: begin
          if (ch == CH_SLASH) begin
            mode_next = M_IDLE;
          end else if (ch != CH_STAR) begin
            mode_next = M_BCOMM;
            if (ch == CH_NL) line_next = line_inc;
          end
        end
        M_STR: begin
          len_next = len_grow;
          if (ch == CH_QUOTE) begin
            push.r0   = make_tok(KIND_STRING, line, st, len_grow, '0, 1'b0, 1'b0, 1'b0);
            push.n    = 2'd1;
            mode_next = M_IDLE;
          end else if (ch == CH_NL) begin
            line_next = line_inc;
          end
        end
        M_SLASH: begin
          if (ch == CH_SLASH) mode_next = M_LCOMM;
          else if (ch == CH_STAR) mode_next = M_BCOMM;
          else taken = 1'b0;
        end
        M_OP: begin
          if (ch == CH_EQ) begin
            len_next  = len_grow;
            push.r0   = make_tok(KIND_EQ + {3'b000, op, 1'b0}, line, st, len_grow, '0,
                                 1'b0, 1'b0, 1'b0);
            push.n    = 2'd1;
            mode_next = M_IDLE;
          end else begin
            taken = 1'b0;
          end
        end
        M_INT: begin
          if (is_dig) begin
            len_next = len_grow;
            {ovf_next, acc_next} = dsum;
          end else if (ch == CH_DOT) begin
            len_next  = len_grow;
            mode_next = M_FRAC;
          end else begin
            taken = 1'b0;
          end
        end
        M_FRAC: begin
          if (is_dig) len_next = len_grow;
          else taken = 1'b0;
        end
        M_IDENT: begin
          if (is_dig || is_alp) begin
            if (len < POS_BITS'(PREFIX_LEN)) pre_next = {pre[PREFIX_BITS-9:0], ch};
            len_next = len_grow;
          end else begin
            taken = 1'b0;
          end
        end
        default: taken = 1'b0;
      endcase

      if (!taken) begin
        mode_next = M_IDLE;
        unique case (ch)
          CH_NL:     line_next = line_inc;
          CH_LPAREN: begin fr_hit = 1'b1; fr_tok.kind = KIND_LPAREN; end
          CH_RPAREN: begin fr_hit = 1'b1; fr_tok.kind = KIND_RPAREN; end
          CH_LBRACE: begin fr_hit = 1'b1; fr_tok.kind = KIND_LBRACE; end
          CH_RBRACE: begin fr_hit = 1'b1; fr_tok.kind = KIND_RBRACE; end
          CH_COMMA:  begin fr_hit = 1'b1; fr_tok.kind = KIND_COMMA; end
          CH_SEMI:   begin fr_hit = 1'b1; fr_tok.kind = KIND_SEMI; end
          CH_PLUS:   begin fr_hit = 1'b1; fr_tok.kind = KIND_PLUS; end
          CH_MINUS:  begin fr_hit = 1'b1; fr_tok.kind = KIND_MINUS; end
          CH_STAR:   begin fr_hit = 1'b1; fr_tok.kind = KIND_STAR; end
          CH_EQ, CH_BANG, CH_GT, CH_LT: begin
            mode_next = M_OP;
            st_next   = pos;
            len_next  = POS_BITS'(1);
            op_next   = (ch == CH_EQ) ? OP_EQ : (ch == CH_BANG) ? OP_BANG :
                        (ch == CH_GT) ? OP_GT : OP_LT;
          end
          CH_SLASH: begin
            mode_next = M_SLASH;
            st_next   = pos;
            len_next  = POS_BITS'(1);
          end
          CH_QUOTE: begin
            mode_next = M_STR;
            st_next   = pos;
            len_next  = POS_BITS'(1);
          end
          default: begin
            if (is_dig) begin
              mode_next = M_INT;
              st_next   = pos;
              len_next  = POS_BITS'(1);
              acc_next  = VALUE_BITS'(ch[3:0]);
              ovf_next  = 1'b0;
            end else if (is_alp) begin
              mode_next = M_IDENT;
              st_next   = pos;
              len_next  = POS_BITS'(1);
              pre_next  = PREFIX_BITS'(ch);
            end
          end
        endcase
        if (fl_hit) begin
          push.r0 = fl_tok;
          push.r1 = fr_tok;
          push.n  = fr_hit ? 2'd2 : 2'd1;
        end else begin
          push.r0 = fr_tok;
          push.n  = fr_hit ? 2'd1 : 2'd0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= M_IDLE;
      op   <= '0;
      line <= LINE_BITS'(1);
      pos  <= '0;
      st   <= '0;
      len  <= '0;
      acc  <= '0;
      ovf  <= 1'b0;
      pre  <= '0;
    end else if (accept) begin
      mode <= mode_next;
      op   <= op_next;
      line <= line_next;
      pos  <= pos_next;
      st   <= st_next;
      len  <= len_next;
      acc  <= acc_next;
      ovf  <= ovf_next;
      pre  <= pre_next;
    end
  end

`ifndef SYNTHESIS
  a_halt_quiet: assert property (@(posedge clk) disable iff (rst)
    mode == M_HALT |-> push.n == 2'd0)
    else $error("tokens produced after end of stream");
  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    mode == M_HALT |=> mode == M_HALT)
    else $error("scanner left halt without reset");
  a_push_range: assert property (@(posedge clk) disable iff (rst)
    push.n != 2'd3)
    else $error("more than two tokens for one character");
`endif

endmodule

[hdl/source_text_tokenizer_top.sv]
// Channel  Dir  Word                                       Accepted when
// s_*      in   tdata[7:0] char_code, tlast end_of_source  s_tvalid && s_tready
// m_*      out  tdata token fields, tuser error, tlast     m_tvalid && m_tready
//
// One character word per cycle while s_tready is high; each word produces zero, one or two tokens.
// Scanner state is registered when a word is accepted; tokens land in a four-word output queue.
// s_tready drops only when the queue holds three or more words.
// rst is synchronous; it returns the scanner to idle with line count one.
// After the end word (or an unterminated string) the block drops input until reset.
module source_text_tokenizer_top import stt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] char_code
  input  logic        s_tlast,   // end_of_source
  output logic        m_tvalid,
  input  logic        m_tready,
  // [5:0] token_kind, [21:6] token_line, [37:22] token_start,
  // [53:38] token_length, [84:54] int_value, [85] value_saturated, [87:86] zero
  output logic [87:0] m_tdata,
  output logic        m_tuser,   // error_flag
  output logic        m_tlast    // last
);

  push_t      push;
  logic       s_acc, m_acc;
  tok_t       q [4];
  logic [1:0] wp, rp;
  logic [2:0] count, count_next;
  tok_t       head;

  assign s_tready = count <= 3'd2;
  assign s_acc    = s_tvalid && s_tready;
  assign m_acc    = m_tvalid && m_tready;

  stt_scan u_scan (
    .clk    (clk),
    .rst    (rst),
    .accept (s_acc),
    .ch     (s_tdata),
    .eos    (s_tlast),
    .push   (push)
  );

  // queue: up to two words written per cycle, one read
  always_ff @(posedge clk) begin
    if (s_acc && push.n != 2'd0) q[wp] <= push.r0;
    if (s_acc && push.n == 2'd2) q[wp + 2'd1] <= push.r1;
  end

  assign count_next = count + (s_acc ? {1'b0, push.n} : 3'd0) - {2'b00, m_acc};

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (s_acc) wp <= wp + push.n;
      if (m_acc) rp <= rp + 2'd1;
      count <= count_next;
    end
  end

  assign head     = q[rp];
  assign m_tvalid = count != 3'd0;
  assign m_tdata  = {2'b00, head.sat, head.value, head.length, head.start, head.line,
                     head.kind};
  assign m_tuser  = head.err;
  assign m_tlast  = head.lst;

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    s_acc |-> ({1'b0, count} + {2'b00, push.n}) <= 4'd4)
    else $error("token queue overrun");
  a_last_alone: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> count == 3'd1)
    else $error("words queued behind the final word");
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("output valid right after reset");
`endif

endmodule
